/* sv/lpc_pkg.sv */
// Shared types, constants and field layout for the layer priority compositor.
package lpc_pkg;

    localparam int unsigned LPC_PAL_ENTRIES = 512;
    localparam int unsigned LPC_PAL_AW      = 9;
    localparam int unsigned LPC_PAL_DW      = 16;

    localparam int unsigned LPC_S_TDATA_W   = 96;
    localparam int unsigned LPC_M_TDATA_W   = 32;
    localparam int unsigned LPC_APB_AW      = 4;

    // Bit offsets of the fields inside the slave-side tdata word.
    localparam int unsigned LPC_OFS_PADDR   = 0;
    localparam int unsigned LPC_OFS_PDATA   = 9;
    localparam int unsigned LPC_OFS_BG0     = 25;
    localparam int unsigned LPC_OFS_BG1     = 33;
    localparam int unsigned LPC_OFS_BG2     = 41;
    localparam int unsigned LPC_OFS_BG3     = 49;
    localparam int unsigned LPC_OFS_BITMAP  = 57;
    localparam int unsigned LPC_OFS_OBJIDX  = 73;
    localparam int unsigned LPC_OFS_OBJPRI  = 81;
    localparam int unsigned LPC_OFS_WIN     = 84;

    localparam logic [2:0] LPC_FIRST_BITMAP_MODE = 3'd3;
    localparam logic [2:0] LPC_NO_PRIORITY       = 3'd4;
    localparam logic [7:0] LPC_ALPHA             = 8'hFF;

    typedef enum logic {
        CMD_PAL_WRITE = 1'b0,
        CMD_PIXEL     = 1'b1
    } t_lpc_cmd;

    typedef enum logic [1:0] {
        REG_VIDEO_MODE = 2'd0,
        REG_BG_ENABLE  = 2'd1,
        REG_BG_PRIO    = 2'd2,
        REG_UNUSED     = 2'd3
    } t_lpc_reg;

    // Decision made for one pixel before the palette lookup.
    typedef struct packed {
        logic [LPC_PAL_AW-1:0] rd_addr;
        logic                  use_bitmap;
    } t_lpc_sel;

endpackage

/* sv/lpc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module lpc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lpc_layer_sel.sv */
// Layer priority resolution: picks the palette entry or bitmap color for one pixel.
module lpc_layer_sel
    import lpc_pkg::*;
(
    input  logic [2:0]  i_video_mode,
    input  logic [3:0]  i_bg_enable,
    input  logic [7:0]  i_bg_priorities,
    input  logic [7:0]  i_bg_index [4],
    input  logic [7:0]  i_obj_index,
    input  logic [2:0]  i_obj_priority,
    input  logic [4:0]  i_window_mask,
    output t_lpc_sel    o_sel
);

    logic       bg_found;
    logic [3:0] best_key;
    logic [7:0] best_index;
    logic [3:0] key;
    logic [2:0] win_pri;
    logic       obj_wins;
    logic       bitmap_mode;

    // Key is {priority, background number}; the smallest qualifying key wins.
    always_comb begin
        bg_found   = 1'b0;
        best_key   = 4'hF;
        best_index = 8'd0;
        key        = 4'd0;
        for (int k = 0; k < 4; k++) begin
            key = {i_bg_priorities[2*k +: 2], 2'(k)};
            if (i_bg_index[k] != 8'd0 && i_bg_enable[k] && i_window_mask[k] &&
                (!bg_found || key < best_key)) begin
                bg_found   = 1'b1;
                best_key   = key;
                best_index = i_bg_index[k];
            end
        end
    end

    assign bitmap_mode = (i_video_mode >= LPC_FIRST_BITMAP_MODE);

    always_comb begin
        if (bitmap_mode) begin
            win_pri = {1'b0, i_bg_priorities[5:4]};
        end else if (bg_found) begin
            win_pri = {1'b0, best_key[3:2]};
        end else begin
            win_pri = LPC_NO_PRIORITY;
        end
    end

    assign obj_wins = (i_obj_index != 8'd0) && (i_obj_priority <= win_pri) &&
                      i_window_mask[4];

    // The object palette occupies the upper half, so its address is 256 plus the index.
    always_comb begin
        o_sel.use_bitmap = bitmap_mode && !obj_wins;
        if (obj_wins) begin
            o_sel.rd_addr = {1'b1, i_obj_index};
        end else begin
            o_sel.rd_addr = {1'b0, best_index};
        end
    end

endmodule

/* sv/layer_priority_compositor_top.sv */
// Top level of the layer priority compositor: stream ports, pipeline and registers.
//
//  Channel  | Direction | Beat content
//  ---------+-----------+--------------------------------------------------------
//  s_axis   | in        | tuser = command; tdata = palette write or pixel fields
//  m_axis   | out       | tdata = pixel_rgba, one beat per pixel command
//  APB      | in/out    | video_mode @0x0, bg_enable @0x4, bg_priorities @0x8
//
// A beat is taken every cycle while the output side keeps up. A pixel passes three
// registers (input stage, palette read stage, output register). A palette write
// finishes in the input stage and produces no output beat.
// Reset is synchronous and active low; it clears the stage valid bits and the
// configuration registers. The palette is not cleared and must be written before use.
// Each stage moves forward when the stage after it is empty or moving, so a
// stalled output only blocks input once every stage behind it is full.
module layer_priority_compositor_top
    import lpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [8:0] palette_address, [24:9] palette_data, [32:25] bg0_index,
    // [40:33] bg1_index, [48:41] bg2_index, [56:49] bg3_index,
    // [72:57] bitmap_color, [80:73] obj_index, [83:81] obj_priority,
    // [88:84] window_mask, [95:89] zero
    input  logic [LPC_S_TDATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic                     s_axis_tuser,

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [31:0] pixel_rgba
    output logic [LPC_M_TDATA_W-1:0] m_axis_tdata,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [LPC_APB_AW-1:0]    paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // Configuration registers.
    logic [2:0] r_video_mode;
    logic [3:0] r_bg_enable;
    logic [7:0] r_bg_priorities;
    logic       cfg_write;
    t_lpc_reg   cfg_reg;

    // Stage 1: registered input beat.
    logic                     r_s1_valid;
    logic                     r_s1_cmd;
    logic [LPC_S_TDATA_W-1:0] r_s1_data;

    // Stage 2: palette read data is registered inside the RAM.
    logic        r_s2_valid;
    logic        r_s2_use_bitmap;
    logic [14:0] r_s2_bitmap;

    // Output register.
    logic                     r_out_valid;
    logic [LPC_M_TDATA_W-1:0] r_out_data;
    logic [LPC_M_TDATA_W-1:0] n_out_data;

    logic out_free;
    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic s1_is_pixel;
    logic s_accept;
    logic pal_we;
    logic pal_re;

    logic [7:0]            bg_index [4];
    t_lpc_sel              sel;
    logic [LPC_PAL_DW-1:0] pal_rdata;
    logic [14:0]           color;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_reg   = t_lpc_reg'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_mode    <= 3'd0;
            r_bg_enable     <= 4'd0;
            r_bg_priorities <= 8'd0;
        end else if (cfg_write) begin
            case (cfg_reg)
                REG_VIDEO_MODE: r_video_mode    <= pwdata[2:0];
                REG_BG_ENABLE:  r_bg_enable     <= pwdata[3:0];
                REG_BG_PRIO:    r_bg_priorities <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg)
            REG_VIDEO_MODE: prdata = {29'd0, r_video_mode};
            REG_BG_ENABLE:  prdata = {28'd0, r_bg_enable};
            REG_BG_PRIO:    prdata = {24'd0, r_bg_priorities};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- flow control
    // A palette write leaves stage 1 without needing stage 2.
    assign s1_is_pixel   = (t_lpc_cmd'(r_s1_cmd) == CMD_PIXEL);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s2_free       = !r_s2_valid || out_free;
    assign s1_go         = r_s1_valid && (!s1_is_pixel || s2_free);
    assign s1_free       = !r_s1_valid || s1_go;
    assign s_axis_tready = s1_free;
    assign s_accept      = s_axis_tvalid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_cmd  <= s_axis_tuser;
            r_s1_data <= s_axis_tdata;
        end
    end

    // ---------------------------------------------------------------- layer selection
    assign bg_index[0] = r_s1_data[LPC_OFS_BG0 +: 8];
    assign bg_index[1] = r_s1_data[LPC_OFS_BG1 +: 8];
    assign bg_index[2] = r_s1_data[LPC_OFS_BG2 +: 8];
    assign bg_index[3] = r_s1_data[LPC_OFS_BG3 +: 8];

    lpc_layer_sel u_layer_sel (
        .i_video_mode    (r_video_mode),
        .i_bg_enable     (r_bg_enable),
        .i_bg_priorities (r_bg_priorities),
        .i_bg_index      (bg_index),
        .i_obj_index     (r_s1_data[LPC_OFS_OBJIDX +: 8]),
        .i_obj_priority  (r_s1_data[LPC_OFS_OBJPRI +: 3]),
        .i_window_mask   (r_s1_data[LPC_OFS_WIN +: 5]),
        .o_sel           (sel)
    );

    // ---------------------------------------------------------------- palette
    // Writes and reads come from stage 1 in beat order, so a pixel always sees
    // every palette write accepted ahead of it.
    assign pal_we = s1_go && !s1_is_pixel;
    assign pal_re = s1_go && s1_is_pixel;

    lpc_ram #(
        .WIDTH (LPC_PAL_DW),
        .DEPTH (LPC_PAL_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_s1_data[LPC_OFS_PADDR +: LPC_PAL_AW]),
        .i_wdata (r_s1_data[LPC_OFS_PDATA +: LPC_PAL_DW]),
        .i_re    (pal_re),
        .i_raddr (sel.rd_addr),
        .o_rdata (pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= pal_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_re) begin
            r_s2_use_bitmap <= sel.use_bitmap;
            r_s2_bitmap     <= r_s1_data[LPC_OFS_BITMAP +: 15];
        end
    end

    // ---------------------------------------------------------------- output
    // Each 5-bit channel times eight is the channel shifted up by three bits.
    assign color      = r_s2_use_bitmap ? r_s2_bitmap : pal_rdata[14:0];
    assign n_out_data = {color[4:0], 3'b000, color[9:5], 3'b000,
                         color[14:10], 3'b000, LPC_ALPHA};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
